### rtl/core/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque core.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int DEPTH   = 64;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CAP_W   = 7;
   localparam int DATA_W  = 32;
   localparam int OP_W    = 3;
   localparam int STAT_W  = 2;

   localparam logic [OP_W-1:0] OP_INS_REAR  = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd1;
   localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_REAR  = 3'd3;
   localparam logic [OP_W-1:0] OP_READ_ALL  = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [STAT_W-1:0]        status;
      logic                     last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DEL_DATA,
      ST_DUMP_ISSUE,
      ST_DUMP_DATA
   } cdq_state_type;

   typedef struct packed {
      logic load_item;
      logic insert;
      logic delete;
      logic del_load;
      logic emit_full;
      logic emit_empty;
      logic dump_start;
      logic dump_issue;
      logic dump_load;
   } cdq_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            empty;
      logic            out_free;
      logic            dump_end;
   } cdq_sts_type;

endpackage

### rtl/core/cdq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/cdq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer for the deque: accepts one item, then steps the datapath.
// ----------------------------------------------------------------------------
module cdq_ctrl
   import cdq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  cdq_sts_type sts,
   output cdq_cmd_type cmd
);

   cdq_state_type state_ff;
   cdq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
               unique case (sts.op) inside
                  OP_INS_REAR, OP_INS_FRONT: begin
                     if (sts.full) begin
                        cmd.emit_full = 1'b1;
                     end else begin
                        cmd.insert = 1'b1;
                     end
                  end
                  OP_DEL_FRONT, OP_DEL_REAR: begin
                     if (sts.empty) begin
                        cmd.emit_empty = 1'b1;
                     end else begin
                        cmd.delete = 1'b1;
                        state_in   = ST_DEL_DATA;
                     end
                  end
                  OP_READ_ALL: begin
                     if (sts.empty) begin
                        cmd.emit_empty = 1'b1;
                     end else begin
                        cmd.dump_start = 1'b1;
                        state_in       = ST_DUMP_ISSUE;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DEL_DATA: begin
            cmd.del_load = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_DUMP_ISSUE: begin
            if (sts.out_free) begin
               cmd.dump_issue = 1'b1;
               state_in       = ST_DUMP_DATA;
            end
         end
         ST_DUMP_DATA: begin
            cmd.dump_load = 1'b1;
            state_in      = sts.dump_end ? ST_IDLE : ST_DUMP_ISSUE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/core/cdq_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_dpath
// Deque datapath: indices, capacity, entry store and result register.
// ----------------------------------------------------------------------------
module cdq_dpath
   import cdq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  req_type          req_data,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  cdq_cmd_type      cmd,
   output cdq_sts_type      sts
);

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] n);
      logic [CAP_W-1:0] inc;
      inc = CAP_W'(i) + CAP_W'(1);
      return (inc >= n) ? '0 : IDX_W'(inc);
   endfunction

   function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] n);
      logic [CAP_W-1:0] top;
      top = n - CAP_W'(1);
      if (i == '0 || CAP_W'(i) >= n) begin
         return IDX_W'(top);
      end
      return i - IDX_W'(1);
   endfunction

   logic [CAP_W-1:0]         cap_ff;
   logic [IDX_W-1:0]         front_ff;
   logic [IDX_W-1:0]         rear_ff;
   logic                     empty_ff;
   logic [IDX_W-1:0]         ptr_ff;
   logic                     end_ff;
   logic [OP_W-1:0]          op_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   logic [CAP_W-1:0]  n;
   logic [IDX_W-1:0]  rear_nx;
   logic [IDX_W-1:0]  front_pv;
   logic              full;
   logic              out_free;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;

   always_comb begin
      if (cap_ff == '0) begin
         n = CAP_W'(1);
      end else if (cap_ff > CAP_W'(DEPTH)) begin
         n = CAP_W'(DEPTH);
      end else begin
         n = cap_ff;
      end
   end

   assign rear_nx  = idx_next(rear_ff, n);
   assign front_pv = idx_prev(front_ff, n);
   assign full     = !empty_ff && (rear_nx == front_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      wr_en   = cmd.insert;
      wr_addr = '0;
      if (!empty_ff) begin
         wr_addr = (op_ff == OP_INS_REAR) ? rear_nx : front_pv;
      end
      rd_en   = cmd.delete || cmd.dump_issue;
      rd_addr = cmd.dump_issue ? ptr_ff
              : ((op_ff == OP_DEL_FRONT) ? front_ff : rear_ff);
   end

   cdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_W'(DEPTH);
         front_ff <= '0;
         rear_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (csr_wr_en) begin
         cap_ff   <= csr_wr_data;
         front_ff <= '0;
         rear_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (cmd.insert) begin
         if (empty_ff) begin
            front_ff <= '0;
            rear_ff  <= '0;
            empty_ff <= 1'b0;
         end else if (op_ff == OP_INS_REAR) begin
            rear_ff <= rear_nx;
         end else begin
            front_ff <= front_pv;
         end
      end else if (cmd.delete) begin
         if (front_ff == rear_ff) begin
            front_ff <= '0;
            rear_ff  <= '0;
            empty_ff <= 1'b1;
         end else if (op_ff == OP_DEL_FRONT) begin
            front_ff <= idx_next(front_ff, n);
         end else begin
            rear_ff <= idx_prev(rear_ff, n);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff    <= req_data.op;
         value_ff <= req_data.value;
      end
      if (cmd.dump_start) begin
         ptr_ff <= front_ff;
      end else if (cmd.dump_issue) begin
         ptr_ff <= idx_next(ptr_ff, n);
         end_ff <= (ptr_ff == rear_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.insert || cmd.emit_full || cmd.emit_empty ||
                   cmd.del_load || cmd.dump_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         rsp_ff <= '{data: '0, status: STAT_OK, last: 1'b1};
      end else if (cmd.emit_full) begin
         rsp_ff <= '{data: '0, status: STAT_FULL, last: 1'b1};
      end else if (cmd.emit_empty) begin
         rsp_ff <= '{data: '0, status: STAT_EMPTY, last: 1'b1};
      end else if (cmd.del_load) begin
         rsp_ff <= '{data: rd_data, status: STAT_OK, last: 1'b1};
      end else if (cmd.dump_load) begin
         rsp_ff <= '{data: rd_data, status: STAT_OK, last: end_ff};
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;
   assign sts.op       = op_ff;
   assign sts.full     = full;
   assign sts.empty    = empty_ff;
   assign sts.out_free = out_free;
   assign sts.dump_end = end_ff;

endmodule

### rtl/core/circular_deque_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_core
// Double-ended queue of 32-bit signed values in a circular entry store.
//
// The core takes one item at a time and holds req_stall high until that
// item's work is finished. A delete, unlike an insert, takes an extra step
// for the registered read port of the entry store. A read-out reads the
// store and then loads the single result register for each stored entry,
// so it reads no further entry until the last result is loaded. A result
// that waits on rsp_stall holds up further work, but the next item is still
// accepted while it waits. Writing the capacity register empties the queue;
// a capacity of zero acts as one and a value above the store depth acts as
// the depth.
// ----------------------------------------------------------------------------
module circular_deque_core
   import cdq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

   cdq_cmd_type cmd;
   cdq_sts_type sts;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cdq_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .sts         (sts)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted item did not make the core busy");

   a_insert_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !sts.full)
      else $error("insert issued into a full queue");

   a_delete_not_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.delete || cmd.dump_start) |-> !sts.empty)
      else $error("store read started on an empty queue");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.insert || cmd.emit_full || cmd.emit_empty || cmd.del_load ||
       cmd.dump_load) |-> sts.out_free)
      else $error("result register overwritten before it was taken");

endmodule
